FILE: design/thdg_pkg.sv
// Package for the thermal DVFS governor: sizes, codes, item and control structs.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package thdg_pkg;

    // Core array geometry; at most 64 results per tick
    localparam int CORE_ROWS    = 4;
    localparam int CORE_COLUMNS = 4;
    localparam int CORE_TOTAL   = CORE_ROWS * CORE_COLUMNS;
    localparam int NUM_CORES    = (CORE_TOTAL > 64) ? 64 : CORE_TOTAL;

    // Field widths
    localparam int TEMP_W   = 13;
    localparam int FREQ_W   = 13;
    localparam int MASK_W   = 16;
    localparam int IDX_W    = 6;
    localparam int ACT_W    = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 13;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_CORES - 1);
    localparam logic [IDX_W-1:0] MASK_SPAN = IDX_W'(MASK_W);

    // Scaling: freq * factor / PCT, then rounding by the step
    localparam int FACT_W = 7;
    localparam logic [FACT_W-1:0] SCALE_DOWN = FACT_W'(80);
    localparam logic [FACT_W-1:0] SCALE_UP   = FACT_W'(120);
    localparam logic [FACT_W-1:0] PCT        = FACT_W'(100);
    localparam int PROD_W   = FREQ_W + FACT_W;
    localparam int SCALED_W = FREQ_W + 1;

    // Division by PCT as a reciprocal multiply; exact for products below 2**PROD_W
    localparam int RECIP_SH = 27;
    localparam int RECIP_W  = 21;
    localparam logic [RECIP_W-1:0] RECIP_PCT =
        RECIP_W'((2**RECIP_SH + int'(PCT) - 1) / int'(PCT));

    // Step divider
    localparam int DIV_W     = SCALED_W;
    localparam int DSR_W     = FREQ_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Item queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_CRITICAL_TEMP  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_RECOVERED_TEMP = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_MIN_FREQ       = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_MAX_FREQ       = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_FREQ_STEP      = 3'd4;

    // Reset values
    localparam logic signed [TEMP_W-1:0] CRIT_RST  = 13'sd1280;
    localparam logic signed [TEMP_W-1:0] RECOV_RST = 13'sd1248;
    localparam logic [FREQ_W-1:0] MIN_RST  = 13'd1000;
    localparam logic [FREQ_W-1:0] MAX_RST  = 13'd4000;
    localparam logic [FREQ_W-1:0] STEP_RST = 13'd100;

    typedef enum logic [ACT_W-1:0] {
        ACT_HOLD = 2'd0,
        ACT_DOWN = 2'd1,
        ACT_UP   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PCT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CLAMP,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] critical_temp;
        logic signed [TEMP_W-1:0] recovered_temp;
        logic [FREQ_W-1:0]        min_freq;
        logic [FREQ_W-1:0]        max_freq;
        logic [FREQ_W-1:0]        freq_step;
    } cfg_t;

    typedef struct packed {
        action_t           action;
        logic [MASK_W-1:0] active_cores;
    } q_item_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DSR_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: design/thdg_front.sv
// Front part: takes tick items, classifies the thermal action, holds one item for the queue.
// Depends on thdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thdg_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire thdg_pkg::cfg_t           cfg,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [thdg_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  wire logic                     q_full,
    output logic                          q_push,
    output thdg_pkg::q_item_t             q_item
);
    import thdg_pkg::*;

    logic                     item_valid_reg;
    q_item_t                  item_reg;
    q_item_t                  item_next;
    logic signed [TEMP_W-1:0] peak;
    logic                     accept;

    assign peak = $signed(s_axis_tdata[TEMP_W-1:0]);

    // Step down wins when both thresholds are crossed
    always_comb begin
        item_next.active_cores = s_axis_tdata[TEMP_W +: MASK_W];
        if (peak > cfg.critical_temp) begin
            item_next.action = ACT_DOWN;
        end else if (peak < cfg.recovered_temp) begin
            item_next.action = ACT_UP;
        end else begin
            item_next.action = ACT_HOLD;
        end
    end

    assign q_push        = item_valid_reg && !q_full;
    assign s_axis_tready = !item_valid_reg || !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign q_item        = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (accept) begin
            item_valid_reg <= 1'b1;
        end else if (q_push) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/thdg_fifo.sv
// Two-entry queue of classified ticks between the front and back parts.
// Depends on thdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thdg_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire thdg_pkg::q_item_t push_item,
    output logic                   full,
    input  wire logic              pop,
    output thdg_pkg::q_item_t      pop_item,
    output logic                   empty
);
    import thdg_pkg::*;

    q_item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: design/thdg_div.sv
// Restoring divider, one quotient bit per cycle; gives the remainder for the step rounding.
// Depends on thdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thdg_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire thdg_pkg::div_req_t req,
    output thdg_pkg::div_rsp_t      rsp
);
    import thdg_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DSR_W:0]       rem_shift;
    logic [DSR_W:0]       rem_sub;
    logic                 qbit;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign qbit      = (rem_shift >= {1'b0, dsr_reg});
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], qbit};
            rem_reg <= qbit ? rem_sub[DSR_W-1:0] : rem_shift[DSR_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: design/thdg_back.sv
// Back part: on a step scales, rounds and clamps the shared frequency, then emits one item per core.
// Depends on thdg_pkg; instantiates nothing, drives the serial divider by struct.
`timescale 1ns / 1ps
`default_nettype none

module thdg_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire thdg_pkg::cfg_t        cfg,
    input  wire logic                  q_empty,
    input  wire thdg_pkg::q_item_t     q_item,
    output logic                       q_pop,
    output thdg_pkg::div_req_t         div_req,
    input  wire thdg_pkg::div_rsp_t    div_rsp,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [thdg_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast
);
    import thdg_pkg::*;

    back_state_t          state_reg;
    back_state_t          state_next;
    action_t              action_reg;
    logic [MASK_W-1:0]    active_reg;
    logic [FREQ_W-1:0]    shared_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SCALED_W-1:0]  scaled_reg;
    logic [SCALED_W-1:0]  rounded_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 m_valid_reg;
    logic [IDX_W-1:0]     m_index_reg;
    logic [FREQ_W-1:0]    m_freq_reg;
    action_t              m_action_reg;
    logic                 m_last_reg;
    logic                 load_out;
    logic                 core_on;
    logic [FACT_W-1:0]    factor;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [FREQ_W-1:0]    step_eff;
    logic [FREQ_W-1:0]    clamp_hi;
    logic [FREQ_W-1:0]    clamp_val;

    assign factor   = (action_reg == ACT_DOWN) ? SCALE_DOWN : SCALE_UP;
    // Divide the product by a hundred through the reciprocal
    assign recip_prod = prod_reg * RECIP_PCT;
    // Zero step means no rounding
    assign step_eff = (cfg.freq_step == '0) ? FREQ_W'(1) : cfg.freq_step;
    // Upper bound first, then lower bound, so min wins on overlap
    assign clamp_hi  = (rounded_reg > {1'b0, cfg.max_freq}) ? cfg.max_freq
                                                           : rounded_reg[FREQ_W-1:0];
    assign clamp_val = (clamp_hi < cfg.min_freq) ? cfg.min_freq : clamp_hi;
    assign core_on   = (idx_reg < MASK_SPAN) && active_reg[idx_reg[3:0]];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = (q_item.action == ACT_HOLD) ? ST_EMIT : ST_MUL;
                end
            end
            ST_MUL:      state_next = ST_PCT;
            ST_PCT:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_rsp.done) state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_EMIT;
            ST_EMIT: begin
                if (load_out && idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        q_pop            = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = scaled_reg;
        div_req.divisor  = step_eff;
        case (state_reg)
            ST_IDLE:   q_pop = !q_empty;
            ST_DIV_GO: div_req.start = 1'b1;
            ST_EMIT:   load_out = !m_valid_reg || m_axis_tready;
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            shared_reg  <= MIN_RST;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLAMP) begin
                shared_reg <= clamp_val;
            end
            if (q_pop) begin
                idx_reg <= '0;
            end else if (load_out) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            action_reg <= q_item.action;
            active_reg <= q_item.active_cores;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= shared_reg * factor;
        end
        if (state_reg == ST_PCT) begin
            scaled_reg <= recip_prod[RECIP_SH +: SCALED_W];
        end
        if (state_reg == ST_DIV_WAIT && div_rsp.done) begin
            rounded_reg <= scaled_reg - {1'b0, div_rsp.remainder};
        end
        if (load_out) begin
            m_index_reg  <= idx_reg;
            m_freq_reg   <= core_on ? shared_reg : cfg.min_freq;
            m_action_reg <= action_reg;
            m_last_reg   <= (idx_reg == LAST_IDX);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - IDX_W - FREQ_W - ACT_W){1'b0}},
                            m_action_reg, m_freq_reg, m_index_reg};
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_clamp_min: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(state_reg == ST_CLAMP))
            |-> (shared_reg >= $past(cfg.min_freq)))
        else $error("shared frequency below lower bound after clamp");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished while sequencer not waiting");

    a_last_ends_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && idx_reg == LAST_IDX) |=> (state_reg == ST_IDLE && m_last_reg))
        else $error("final core item did not close the tick");
`endif

endmodule

`default_nettype wire

FILE: design/thermal_dvfs_governor_top.sv
// Top level of the thermal DVFS governor: register file, front, queue, divider, back.
// Depends on thdg_pkg, thdg_front, thdg_fifo, thdg_div and thdg_back.
//
// Use: each item on the s_axis channel is one governor tick carrying the peak
// temperature and the active-core mask. The tick compares the peak against
// critical_temp and recovered_temp; a crossing scales the shared frequency to
// 80 or 120 percent, rounds it down to a multiple of freq_step and clamps it.
// m_axis then carries one item per core, in core order, with tlast on the last.
// Configuration: cfg_wr_en/cfg_wr_addr/cfg_wr_data, written while idle.
// Sequence: a held tick goes from the front register through the queue straight
// to the emitter; a scaled tick first passes the scale multiply, the reciprocal
// stage, the serial step divider and the clamp. Results then leave at one per
// cycle while m_axis_tready stays high. The back part finishes one tick before
// it pops the next; further ticks wait in the front and the queue meanwhile.
// Reset (aresetn low, synchronous): registers return to their defaults and the
// shared frequency to 1000 MHz; queue and output register empty.
// Stall: when m_axis_tready is low the output register holds its item and the
// emitter waits; the front and a two-entry queue keep taking ticks meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module thermal_dvfs_governor_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // register write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [thdg_pkg::CFG_A_W-1:0]  cfg_wr_addr,
    input  wire logic [thdg_pkg::CFG_D_W-1:0]  cfg_wr_data,
    // tick items
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [12:0] peak_temperature, [28:13] active_cores, [31:29] zero
    input  wire logic [thdg_pkg::S_DATA_W-1:0] s_axis_tdata,
    // per-core result items
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [5:0] core_index, [18:6] core_freq, [20:19] thermal_action, [23:21] zero
    output logic [thdg_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast
);
    import thdg_pkg::*;

    cfg_t     cfg_reg;
    q_item_t  fr_item;
    q_item_t  q_item;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Register file; writes to unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.critical_temp  <= CRIT_RST;
            cfg_reg.recovered_temp <= RECOV_RST;
            cfg_reg.min_freq       <= MIN_RST;
            cfg_reg.max_freq       <= MAX_RST;
            cfg_reg.freq_step      <= STEP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                REG_CRITICAL_TEMP:  cfg_reg.critical_temp  <= $signed(cfg_wr_data);
                REG_RECOVERED_TEMP: cfg_reg.recovered_temp <= $signed(cfg_wr_data);
                REG_MIN_FREQ:       cfg_reg.min_freq       <= cfg_wr_data;
                REG_MAX_FREQ:       cfg_reg.max_freq       <= cfg_wr_data;
                REG_FREQ_STEP:      cfg_reg.freq_step      <= cfg_wr_data;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Accept and classify ticks
    thdg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (fr_item)
    );

    // Decouple front from back
    thdg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (fr_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    // Serial divider for the step rounding
    thdg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Update the shared frequency and emit per-core items
    thdg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for thermal_dvfs_governor_top: directed and random governor ticks on
// the s_axis channel, with per-core results checked against a built-in predictor.
// Depends on thdg_pkg and the governor RTL only.
`timescale 1ns / 1ps

module tb_top;
    import thdg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_TICKS  = 60;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [FREQ_W-1:0] freq;
        action_t           act;
        logic              last;
    } core_result_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_A_W-1:0]    cfg_wr_addr   = '0;
    logic [CFG_D_W-1:0]    cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;

    // Mirror of the register file and of the shared frequency
    logic signed [TEMP_W-1:0] crit_temp_q   = CRIT_RST;
    logic signed [TEMP_W-1:0] recov_temp_q  = RECOV_RST;
    logic [FREQ_W-1:0]        min_freq_q    = MIN_RST;
    logic [FREQ_W-1:0]        max_freq_q    = MAX_RST;
    logic [FREQ_W-1:0]        freq_step_q   = STEP_RST;
    logic [FREQ_W-1:0]        shared_freq_q = MIN_RST;

    core_result_t expected_cores[$];
    int           mismatches = 0;
    int           cycles     = 0;
    bit           no_gaps    = 1'b0;

    thermal_dvfs_governor_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_addr   (cfg_wr_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Give up on a hung block
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Scale by factor percent, round down to the step, clamp to max then min
    function automatic logic [FREQ_W-1:0] rescale(input logic [FREQ_W-1:0] f,
                                                  input logic [FACT_W-1:0] factor);
        int unsigned v;
        int unsigned stp;
        v   = (32'(f) * 32'(factor)) / 32'(PCT);
        stp = (freq_step_q == '0) ? 1 : 32'(freq_step_q);
        v   = (v / stp) * stp;
        if (v > 32'(max_freq_q))
            v = 32'(max_freq_q);
        if (v < 32'(min_freq_q))
            v = 32'(min_freq_q);
        return v[FREQ_W-1:0];
    endfunction

    function automatic void predict_tick(input logic signed [TEMP_W-1:0] peak,
                                         input logic [MASK_W-1:0] mask);
        action_t      act;
        core_result_t r;
        act = ACT_HOLD;
        // Step down wins when both thresholds are crossed
        if (peak > crit_temp_q) begin
            shared_freq_q = rescale(shared_freq_q, SCALE_DOWN);
            act = ACT_DOWN;
        end else if (peak < recov_temp_q) begin
            shared_freq_q = rescale(shared_freq_q, SCALE_UP);
            act = ACT_UP;
        end
        for (int i = 0; i < NUM_CORES; i++) begin
            r.idx  = IDX_W'(i);
            // Cores past the mask width are always idle
            r.freq = ((i < MASK_W) && mask[i % MASK_W]) ? shared_freq_q : min_freq_q;
            r.act  = act;
            r.last = (i == NUM_CORES - 1);
            expected_cores.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_field(input string name, input int want, input int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge aclk) begin : check_results
        core_result_t want;
        core_result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.idx  = m_axis_tdata[IDX_W-1:0];
            got.freq = m_axis_tdata[IDX_W +: FREQ_W];
            got.act  = action_t'(m_axis_tdata[IDX_W+FREQ_W +: ACT_W]);
            got.last = m_axis_tlast;
            if (expected_cores.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item, expected none, actual core %0d freq %0d",
                         $time, got.idx, got.freq);
            end else begin
                want = expected_cores.pop_front();
                if (got.idx !== want.idx)
                    report_field("core_index", want.idx, got.idx);
                if (got.freq !== want.freq)
                    report_field("core_freq", want.freq, got.freq);
                if (got.act !== want.act)
                    report_field("thermal_action", want.act, got.act);
                if (got.last !== want.last)
                    report_field("tlast", want.last, got.last);
                if (m_axis_tdata[M_DATA_W-1:IDX_W+FREQ_W+ACT_W] !== '0)
                    report_field("tdata padding", 0, m_axis_tdata[M_DATA_W-1:IDX_W+FREQ_W+ACT_W]);
            end
        end
    end

    // Result side back-pressure, dropped during the no-gap stretch
    always @(negedge aclk)
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 38);

    // ------------------------------------------------------------------
    // Shared drivers; every task starts and ends on a falling edge
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input int value);
        logic [CFG_D_W-1:0] data;
        data = CFG_D_W'(value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= addr;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_CRITICAL_TEMP:  crit_temp_q  = data;
            REG_RECOVERED_TEMP: recov_temp_q = data;
            REG_MIN_FREQ:       min_freq_q   = data;
            REG_MAX_FREQ:       max_freq_q   = data;
            REG_FREQ_STEP:      freq_step_q  = data;
            default: ;
        endcase
    endtask

    task automatic send_tick(input int peak_c, input logic [MASK_W-1:0] mask);
        logic signed [TEMP_W-1:0] peak;
        int                       idle_cycles;
        peak = TEMP_W'(peak_c);
        idle_cycles = 0;
        if (!no_gaps) begin
            // Mostly short gaps, now and then a long one to land mid-computation
            if ($urandom_range(0, 9) == 0)
                idle_cycles = $urandom_range(1, 80);
            else
                while ($urandom_range(0, 99) < 38)
                    idle_cycles++;
        end
        if (idle_cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle_cycles) @(negedge aclk);
        end
        s_axis_tdata  <= S_DATA_W'({mask, peak});
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        predict_tick(peak, mask);
        @(negedge aclk);
    endtask

    // Hold off until every expected item has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_cores.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: hold band, threshold equality, steps down and up
    task automatic test_default_ticks();
        send_tick(1260, 16'hFFFF);
        send_tick(-4096, 16'h0000);
        send_tick(1248, 16'hA5A5);
        send_tick(1280, 16'h5A5A);
        send_tick(1281, 16'h0001);
        send_tick(4095, 16'h8000);
        for (int i = 0; i < 9; i++)
            send_tick(0, MASK_W'($urandom));
    endtask

    // Critical below recovered: a peak between them must step down
    task automatic test_threshold_overlap();
        wait_idle();
        write_reg(REG_CRITICAL_TEMP, 0);
        write_reg(REG_RECOVERED_TEMP, 100);
        send_tick(50, 16'hFFFF);
        send_tick(-1, 16'h00FF);
    endtask

    task automatic test_clamp_and_step();
        // Inverted bounds: the minimum wins
        wait_idle();
        write_reg(REG_MIN_FREQ, 3000);
        write_reg(REG_MAX_FREQ, 2000);
        send_tick(4095, 16'hFFFF);
        // Thresholds out of reach: held ticks leave an out-of-range frequency alone
        wait_idle();
        write_reg(REG_CRITICAL_TEMP, 4095);
        write_reg(REG_RECOVERED_TEMP, -4096);
        send_tick(4095, 16'hF0F0);
        send_tick(-4096, 16'h0F0F);
        // Zero step behaves as no rounding
        wait_idle();
        write_reg(REG_RECOVERED_TEMP, 4095);
        write_reg(REG_FREQ_STEP, 0);
        write_reg(REG_MIN_FREQ, 1);
        write_reg(REG_MAX_FREQ, 8191);
        send_tick(-4096, 16'hFFFF);
        send_tick(100, 16'h1234);
        // Largest step rounds everything to zero, so the minimum takes over
        wait_idle();
        write_reg(REG_FREQ_STEP, 8191);
        send_tick(0, 16'hFFFF);
        // Both bounds at the top: scaled value overflows past 13 bits
        wait_idle();
        write_reg(REG_FREQ_STEP, 1);
        write_reg(REG_MIN_FREQ, 8191);
        send_tick(0, 16'hFFFF);
        send_tick(0, 16'hFFFF);
    endtask

    task automatic apply_random_settings(input int phase);
        int crit;
        int recov;
        int fmin;
        int fmax;
        int fstep;
        crit = $urandom_range(0, 8191) - 4096;
        if ($urandom_range(0, 4) == 0)
            recov = $urandom_range(0, 8191) - 4096;
        else
            recov = crit - $urandom_range(0, 64);
        if (recov < -4096)
            recov = -4096;
        fmin = $urandom_range(1, 2500);
        fmax = ($urandom_range(0, 5) == 0) ? $urandom_range(1, fmin)
                                           : $urandom_range(fmin, 8191);
        fstep = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 400);
        if (phase == 0) begin
            // Widest range, finest step
            fmin  = 1;
            fmax  = 8191;
            fstep = 1;
        end
        wait_idle();
        write_reg(REG_CRITICAL_TEMP, crit);
        write_reg(REG_RECOVERED_TEMP, recov);
        write_reg(REG_MIN_FREQ, fmin);
        write_reg(REG_MAX_FREQ, fmax);
        write_reg(REG_FREQ_STEP, fstep);
    endtask

    task automatic test_random_ticks();
        int                lo;
        int                hi;
        int                peak;
        logic [MASK_W-1:0] mask;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            apply_random_settings(ph);
            no_gaps = (ph == 3);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // Half the peaks land around the two thresholds
                lo = ((crit_temp_q < recov_temp_q) ? int'(crit_temp_q) : int'(recov_temp_q)) - 40;
                hi = ((crit_temp_q > recov_temp_q) ? int'(crit_temp_q) : int'(recov_temp_q)) + 40;
                if (lo < -4096)
                    lo = -4096;
                if (hi > 4095)
                    hi = 4095;
                if ($urandom_range(0, 1) == 0)
                    peak = lo + int'($urandom_range(0, hi - lo));
                else
                    peak = $urandom_range(0, 8191) - 4096;
                case ($urandom_range(0, 9))
                    0:       mask = '0;
                    1:       mask = '1;
                    default: mask = MASK_W'($urandom);
                endcase
                send_tick(peak, mask);
            end
            no_gaps = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_ticks();
        test_threshold_overlap();
        test_clamp_and_step();
        test_random_ticks();

        // Drain, then watch for stray items
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && expected_cores.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
